@@ rtl/bqsf_pkg.sv @@
// Shared types and constants for the Brown quadratic smoothing forecaster.
// Holds payload structs, operation codes and the controller/datapath command bundle.
// No dependencies.
package bqsf_pkg;

   // Field widths fixed by the data format
   localparam int SAMPLE_WIDTH = 32;   // Q16.16 sample and levels
   localparam int COEF_WIDTH   = 40;   // Q24.16 coefficients and forecast
   localparam int ALPHA_WIDTH  = 16;   // Q0.16 smoothing factor
   localparam int GAIN_WIDTH   = 24;   // Q8.16 gains
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALPHA      = 2'd0,
      CSR_TREND_GAIN = 2'd1,
      CSR_CURVE_GAIN = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET      = 16'd9830;
   localparam logic [GAIN_WIDTH-1:0]  TREND_GAIN_RESET = 24'd6786;
   localparam logic [GAIN_WIDTH-1:0]  CURVE_GAIN_RESET = 24'd2041;

   // Products computed on the shared multiplier, in issue order
   typedef enum logic [2:0] {
      OP_BLEND1  = 3'd0,   // level one towards the sample
      OP_BLEND2  = 3'd1,   // level two towards level one
      OP_BLEND3  = 3'd2,   // level three towards level two
      OP_ALPHA_E = 3'd3,   // alpha times the E sum
      OP_TREND   = 3'd4,   // weighted sum times trend gain
      OP_CURVE   = 3'd5    // curvature sum times curve gain
   } op_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           start_series;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] level_one;
      logic signed [SAMPLE_WIDTH-1:0] level_two;
      logic signed [SAMPLE_WIDTH-1:0] level_three;
      logic signed [COEF_WIDTH-1:0]   coef_level;
      logic signed [COEF_WIDTH-1:0]   coef_slope;
      logic signed [COEF_WIDTH-1:0]   coef_curve;
      logic signed [COEF_WIDTH-1:0]   forecast;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic   accept;   // input transaction taken this cycle
      logic   load;     // first sample of a series: load all levels
      logic   set;      // form operand magnitude and gain
      logic   mul_lo;   // low digit product plus rounding
      logic   mul_hi;   // high digit product accumulate
      logic   fin;      // round, restore sign, write back
      logic   out;      // load the result register
      op_type op;
   } bqsf_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;   // result register empty or being taken
   } bqsf_status_type;

endpackage

@@ rtl/bqsf_ctrl.sv @@
// Sequencer: steps six shared-multiplier products per sample, three at a series start.
// Depends on bqsf_pkg; drives bqsf_datapath through bqsf_cmd_type.
module bqsf_ctrl import bqsf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_start,
   output logic            req_ready,
   input  bqsf_status_type status,
   output bqsf_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SET  = 6'b000010,
      ST_LO   = 6'b000100,
      ST_HI   = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      started_ff, started_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // Next state and command decode
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      started_in = started_ff;
      cmd        = '0;
      cmd.op     = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               cmd.load   = req_start | ~started_ff;
               started_in = 1'b1;
               // a fresh series skips the level updates
               op_in      = (req_start | ~started_ff) ? OP_ALPHA_E : OP_BLEND1;
               state_in   = ST_SET;
            end
         end
         ST_SET: begin
            cmd.set  = 1'b1;
            state_in = ST_LO;
         end
         ST_LO: begin
            cmd.mul_lo = 1'b1;
            // level differences fit the low digit
            if (op_ff inside {OP_BLEND1, OP_BLEND2, OP_BLEND3}) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_HI;
            end
         end
         ST_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_SET;
            case (op_ff)
               OP_BLEND1:  op_in = OP_BLEND2;
               OP_BLEND2:  op_in = OP_BLEND3;
               OP_BLEND3:  op_in = OP_ALPHA_E;
               OP_ALPHA_E: op_in = OP_TREND;
               OP_TREND:   op_in = OP_CURVE;
               OP_CURVE:   state_in = ST_OUT;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         op_ff      <= OP_BLEND1;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         started_ff <= started_in;
      end
   end

endmodule

@@ rtl/bqsf_datapath.sv @@
// Datapath for the forecaster: levels, config registers, shared 32x24 multiplier,
// coefficient registers and the result register. Depends on bqsf_pkg.
module bqsf_datapath import bqsf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  bqsf_cmd_type          cmd,
   output bqsf_status_type       status,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int OPND_W  = COEF_WIDTH;             // operand and intermediate sums
   localparam int DIGIT_W = 32;                     // low digit of the multiplier
   localparam int HI_W    = OPND_W - DIGIT_W;
   localparam int ACC_W   = 64;
   localparam int FRAC_W  = 16;
   localparam int Q_W     = ACC_W - FRAC_W;
   localparam int QS_W    = Q_W + 1;
   localparam logic [FRAC_W-1:0] RND_UP   = FRAC_W'(1) << (FRAC_W - 1);
   localparam logic [FRAC_W-1:0] RND_DOWN = RND_UP - FRAC_W'(1);

   // Clamp to the coefficient range
   function automatic logic signed [COEF_WIDTH-1:0] sat_coef(
      input logic signed [QS_W-1:0] v
   );
      logic [QS_W-COEF_WIDTH:0] top;
      top = v[QS_W-1:COEF_WIDTH-1];
      if (top == '0 || top == '1) begin
         return v[COEF_WIDTH-1:0];
      end else if (v[QS_W-1]) begin
         return {1'b1, {(COEF_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COEF_WIDTH-1){1'b1}}};
      end
   endfunction

   // Config registers
   logic [ALPHA_WIDTH-1:0] alpha_ff, alpha_in;
   logic [GAIN_WIDTH-1:0]  trend_gain_ff, trend_gain_in;
   logic [GAIN_WIDTH-1:0]  curve_gain_ff, curve_gain_in;

   // State and working registers
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] l1_ff, l1_in, l2_ff, l2_in, l3_ff, l3_in;
   logic [OPND_W-1:0]              mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic [GAIN_WIDTH-1:0]          gain_ff, gain_in;
   logic [ACC_W-1:0]               acc_ff, acc_in;
   logic signed [OPND_W-1:0]       w_ff, w_in;
   logic signed [COEF_WIDTH-1:0]   a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_data_ff, rsp_data_in;

   // Combinational terms
   logic signed [OPND_W-1:0]       x_e, l1_e, l2_e, l3_e;
   logic signed [OPND_W-1:0]       sum_e, sum_d, sum_s, opnd;
   logic [DIGIT_W+GAIN_WIDTH-1:0]  lo_prod;
   logic [HI_W+GAIN_WIDTH-1:0]     hi_prod;
   logic [FRAC_W-1:0]              rnd;
   logic                           is_blend;
   logic [Q_W-1:0]                 q;
   logic signed [QS_W-1:0]         q_pos, qs, old_e, lvl_sum;
   logic signed [QS_W-1:0]         a_w, b_w, c_w, f2;

   // Config writes
   always_comb begin
      alpha_in      = alpha_ff;
      trend_gain_in = trend_gain_ff;
      curve_gain_in = curve_gain_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA:      alpha_in      = csr_data[ALPHA_WIDTH-1:0];
            CSR_TREND_GAIN: trend_gain_in = csr_data[GAIN_WIDTH-1:0];
            CSR_CURVE_GAIN: curve_gain_in = csr_data[GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Level sums used by the coefficients
   always_comb begin
      x_e  = {{(OPND_W-SAMPLE_WIDTH){x_ff[SAMPLE_WIDTH-1]}}, x_ff};
      l1_e = {{(OPND_W-SAMPLE_WIDTH){l1_ff[SAMPLE_WIDTH-1]}}, l1_ff};
      l2_e = {{(OPND_W-SAMPLE_WIDTH){l2_ff[SAMPLE_WIDTH-1]}}, l2_ff};
      l3_e = {{(OPND_W-SAMPLE_WIDTH){l3_ff[SAMPLE_WIDTH-1]}}, l3_ff};
      // E = 5l1 - 8l2 + 3l3
      sum_e = (l1_e <<< 2) + l1_e - (l2_e <<< 3) + (l3_e <<< 1) + l3_e;
      // D = 6l1 - 10l2 + 4l3
      sum_d = (l1_e <<< 2) + (l1_e <<< 1) - (l2_e <<< 3) - (l2_e <<< 1) + (l3_e <<< 2);
      // l1 - 2l2 + l3
      sum_s = l1_e - (l2_e <<< 1) + l3_e;
   end

   // Operand select for the current product
   always_comb begin
      case (cmd.op)
         OP_BLEND1:  opnd = x_e - l1_e;
         OP_BLEND2:  opnd = l1_e - l2_e;
         OP_BLEND3:  opnd = l2_e - l3_e;
         OP_ALPHA_E: opnd = sum_e;
         OP_TREND:   opnd = w_ff;
         OP_CURVE:   opnd = sum_s;
         default:    opnd = '0;
      endcase
   end

   assign is_blend = cmd.op inside {OP_BLEND1, OP_BLEND2, OP_BLEND3};
   // blends round the signed product half up; gain products round half away from zero
   assign rnd      = (neg_ff && is_blend) ? RND_DOWN : RND_UP;
   assign lo_prod  = mag_ff[DIGIT_W-1:0] * gain_ff;
   assign hi_prod  = mag_ff[OPND_W-1:DIGIT_W] * gain_ff;
   assign q        = acc_ff[ACC_W-1:FRAC_W];
   assign q_pos    = $signed({1'b0, q});
   assign qs       = neg_ff ? -q_pos : q_pos;

   // Forecast from saturated coefficients, (2a + 2b + c + 1) floored by two
   always_comb begin
      a_w = {{(QS_W-COEF_WIDTH){a_ff[COEF_WIDTH-1]}}, a_ff};
      b_w = {{(QS_W-COEF_WIDTH){b_ff[COEF_WIDTH-1]}}, b_ff};
      c_w = {{(QS_W-COEF_WIDTH){c_ff[COEF_WIDTH-1]}}, c_ff};
      f2  = (a_w <<< 1) + (b_w <<< 1) + c_w + QS_W'(1);
   end

   // Working registers
   always_comb begin
      x_in    = x_ff;
      l1_in   = l1_ff;
      l2_in   = l2_ff;
      l3_in   = l3_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      gain_in = gain_ff;
      acc_in  = acc_ff;
      w_in    = w_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      old_e   = '0;
      lvl_sum = '0;

      if (cmd.accept) begin
         x_in = req_data.sample;
         if (cmd.load) begin
            l1_in = req_data.sample;
            l2_in = req_data.sample;
            l3_in = req_data.sample;
         end
      end

      // operand magnitude, sign and gain
      if (cmd.set) begin
         neg_in = opnd[OPND_W-1];
         mag_in = opnd[OPND_W-1] ? OPND_W'(-opnd) : OPND_W'(opnd);
         case (cmd.op)
            OP_TREND: gain_in = trend_gain_ff;
            OP_CURVE: gain_in = curve_gain_ff;
            default:  gain_in = {{(GAIN_WIDTH-ALPHA_WIDTH){1'b0}}, alpha_ff};
         endcase
         // levels are final once the E product starts; a = 3l1 - 3l2 + l3
         if (cmd.op == OP_ALPHA_E) begin
            a_in = (l1_e <<< 1) + l1_e - (l2_e <<< 1) - l2_e + l3_e;
         end
      end

      if (cmd.mul_lo) begin
         acc_in = ACC_W'(lo_prod) + ACC_W'(rnd);
      end

      if (cmd.mul_hi) begin
         acc_in = acc_ff + (ACC_W'(hi_prod) << DIGIT_W);
      end

      // write back the rounded product
      if (cmd.fin) begin
         case (cmd.op)
            OP_BLEND1: old_e = {{(QS_W-SAMPLE_WIDTH){l1_ff[SAMPLE_WIDTH-1]}}, l1_ff};
            OP_BLEND2: old_e = {{(QS_W-SAMPLE_WIDTH){l2_ff[SAMPLE_WIDTH-1]}}, l2_ff};
            default:   old_e = {{(QS_W-SAMPLE_WIDTH){l3_ff[SAMPLE_WIDTH-1]}}, l3_ff};
         endcase
         lvl_sum = old_e + qs;
         case (cmd.op)
            OP_BLEND1:  l1_in = lvl_sum[SAMPLE_WIDTH-1:0];
            OP_BLEND2:  l2_in = lvl_sum[SAMPLE_WIDTH-1:0];
            OP_BLEND3:  l3_in = lvl_sum[SAMPLE_WIDTH-1:0];
            OP_ALPHA_E: w_in  = sum_d - qs[OPND_W-1:0];
            OP_TREND:   b_in  = sat_coef(qs);
            OP_CURVE:   c_in  = sat_coef(qs);
            default: ;
         endcase
      end
   end

   // Result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.out) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.level_one   = l1_ff;
         rsp_data_in.level_two   = l2_ff;
         rsp_data_in.level_three = l3_ff;
         rsp_data_in.coef_level  = a_ff;
         rsp_data_in.coef_slope  = b_ff;
         rsp_data_in.coef_curve  = c_ff;
         rsp_data_in.forecast    = sat_coef(f2 >>> 1);
      end
   end

   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff      <= ALPHA_RESET;
         trend_gain_ff <= TREND_GAIN_RESET;
         curve_gain_ff <= CURVE_GAIN_RESET;
         l1_ff         <= '0;
         l2_ff         <= '0;
         l3_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         alpha_ff      <= alpha_in;
         trend_gain_ff <= trend_gain_in;
         curve_gain_ff <= curve_gain_in;
         l1_ff         <= l1_in;
         l2_ff         <= l2_in;
         l3_ff         <= l3_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      gain_ff     <= gain_in;
      acc_ff      <= acc_in;
      w_ff        <= w_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/brown_quadratic_smoothing_forecast.sv @@
// Brown quadratic smoothing forecaster, top level. Uses bqsf_pkg, bqsf_ctrl, bqsf_datapath.
// One transaction at a time: the next sample is accepted only once the current result has
// been loaded into the output register. One shared 32x24 multiplier forms the products in
// turn: six for a continuing sample, three for a series start, which skips the level updates.
// A waiting result holds in the output register; the next transaction is taken meanwhile.
// Synchronous reset clears levels, series flag and output valid, and reloads the gains.
module brown_quadratic_smoothing_forecast import bqsf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   bqsf_cmd_type    cmd;
   bqsf_status_type status;

   // Sequencer
   bqsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_start (req_data.start_series),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage
   bqsf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for brown_quadratic_smoothing_forecast: the three smoothing levels,
// the quadratic coefficients and the forecast are predicted per sample and compared on return.
// Depends on bqsf_pkg and the RTL top level only.
module tb_top import bqsf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COEF_MAX     = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
   localparam longint COEF_MIN     = -(longint'(1) <<< (COEF_WIDTH - 1));
   localparam int     SETTLE_CYC   = 30;      // settling margin after the expectation queue empties
   localparam int     END_WAIT_CYC = 20000;
   localparam int     REPORT_MAX   = 40;
   localparam int     PHASE_ITEMS  = 200;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Predictor state and register copies
   longint                 lvl_one, lvl_two, lvl_three;
   bit                     series_seen;
   logic [ALPHA_WIDTH-1:0] alpha_q;
   logic [GAIN_WIDTH-1:0]  trend_q, curve_q;

   rsp_type expected_forecasts[$];
   int      mismatch_count  = 0;
   int      send_idle_pct   = 0;
   int      rsp_stall_pct   = 0;
   int      rsp_hold_cycles = 0;

   brown_quadratic_smoothing_forecast uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial forever #5ns clock = ~clock;

   // Limit on the whole run
   initial begin
      #5ms;
      $display("tb_top: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // alpha*driver + (1-alpha)*old, round half up
   function automatic longint blend_level(longint driver, longint old);
      longint a_q;
      longint acc;
      a_q = longint'(alpha_q);
      acc = a_q * driver + (65536 - a_q) * old + 32768;
      return acc >>> 16;
   endfunction

   // Q16 product, rounded half away from zero
   function automatic longint gain_product(longint v, longint unsigned gain);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? -v : v;
      q   = (mag * gain + 64'd32768) >> 16;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_coef(longint v);
      if (v > COEF_MAX) return COEF_MAX;
      if (v < COEF_MIN) return COEF_MIN;
      return v;
   endfunction

   // Advances the level state by one sample and forms the expected result
   function automatic rsp_type predict_forecast(req_type item);
      rsp_type r;
      longint  x, a, b, c, d, e, w, f;
      x = longint'(item.sample);
      if (item.start_series || !series_seen) begin
         lvl_one     = x;
         lvl_two     = x;
         lvl_three   = x;
         series_seen = 1'b1;
      end else begin
         lvl_one   = blend_level(x, lvl_one);
         lvl_two   = blend_level(lvl_one, lvl_two);
         lvl_three = blend_level(lvl_two, lvl_three);
      end
      a = clamp_coef(3 * lvl_one - 3 * lvl_two + lvl_three);
      d = 6 * lvl_one - 10 * lvl_two + 4 * lvl_three;
      e = 5 * lvl_one - 8 * lvl_two + 3 * lvl_three;
      w = d - gain_product(e, 64'(alpha_q));
      b = clamp_coef(gain_product(w, 64'(trend_q)));
      c = clamp_coef(gain_product(lvl_one - 2 * lvl_two + lvl_three, 64'(curve_q)));
      f = clamp_coef((2 * a + 2 * b + c + 1) >>> 1);
      r.level_one   = lvl_one[SAMPLE_WIDTH-1:0];
      r.level_two   = lvl_two[SAMPLE_WIDTH-1:0];
      r.level_three = lvl_three[SAMPLE_WIDTH-1:0];
      r.coef_level  = a[COEF_WIDTH-1:0];
      r.coef_slope  = b[COEF_WIDTH-1:0];
      r.coef_curve  = c[COEF_WIDTH-1:0];
      r.forecast    = f[COEF_WIDTH-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   task automatic check_field(string name, longint got, longint want);
      if (got != want) report_mismatch(name, got, want);
   endtask

   // Result transactions are compared with the oldest expectation
   initial forever begin
      rsp_type want;
      @(posedge clock);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_forecasts.size() == 0) begin
            report_mismatch("unexpected result", longint'(rsp_data.forecast), 0);
         end else begin
            want = expected_forecasts.pop_front();
            check_field("level_one",   longint'(rsp_data.level_one),
                        longint'(want.level_one));
            check_field("level_two",   longint'(rsp_data.level_two),
                        longint'(want.level_two));
            check_field("level_three", longint'(rsp_data.level_three),
                        longint'(want.level_three));
            check_field("coef_level",  longint'(rsp_data.coef_level),
                        longint'(want.coef_level));
            check_field("coef_slope",  longint'(rsp_data.coef_slope),
                        longint'(want.coef_slope));
            check_field("coef_curve",  longint'(rsp_data.coef_curve),
                        longint'(want.coef_curve));
            check_field("forecast",    longint'(rsp_data.forecast),
                        longint'(want.forecast));
         end
      end
   end

   // Result side: random stalls, or a counted hold-off when one is requested
   initial forever begin
      @(negedge clock);
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] sample, input logic start);
      req_type item;
      item.sample       = sample;
      item.start_series = start;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_forecasts = {expected_forecasts, predict_forecast(item)};
   endtask

   // Drop valid and let every outstanding result come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_forecasts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_ALPHA:      alpha_q = value[ALPHA_WIDTH-1:0];
         CSR_TREND_GAIN: trend_q = value[GAIN_WIDTH-1:0];
         CSR_CURVE_GAIN: curve_q = value[GAIN_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_gains(input logic [15:0] a, input logic [23:0] tg, input logic [23:0] cg);
      wait_drained();
      write_csr(CSR_ALPHA, {8'd0, a});
      write_csr(CSR_TREND_GAIN, tg);
      write_csr(CSR_CURVE_GAIN, cg);
   endtask

   // One well-formed series: start, then a ramp with curvature and noise
   task automatic send_series();
      int base, step, bend, noise, n;
      case ($urandom_range(3))
         0:       base = int'($urandom);
         1:       base = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         2:       base = 32'sh7FF0_0000 + int'($urandom_range(0, 32'h000F_FFFF));
         default: base = 32'sh8000_0000 + int'($urandom_range(0, 32'h000F_FFFF));
      endcase
      step  = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      bend  = int'($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
      noise = $urandom_range(0, 16);
      n     = $urandom_range(2, 40);
      send_sample(base, 1'b1);
      for (int i = 1; i <= n; i++)
         send_sample(base + step * i + bend * i * i
                     + int'($urandom_range(0, 1 << noise)), 1'b0);
   endtask

   // ---------------------------------------------------------------- tests

   // Default registers: first sample without a series flag, full-range swings
   task automatic test_directed();
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'h0001_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
   endtask

   // Register extremes: alpha zero holds the levels; full gains saturate
   task automatic test_register_extremes();
      set_gains(16'd0, 24'd0, 24'd0);
      send_sample(32'h1234_5678, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      set_gains(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
   endtask

   // Output held off long enough for the block to stall its input
   task automatic test_backpressure();
      set_gains(ALPHA_RESET, TREND_GAIN_RESET, CURVE_GAIN_RESET);
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 300;
      for (int i = 0; i < 10; i++)
         send_sample($urandom, (i == 0));
      wait_drained();
   endtask

   // Mostly well-formed series, some stray transactions with random flags
   task automatic run_random_phase(int idle_pct, int stall_pct);
      int sent_base;
      set_gains(16'($urandom_range(0, 16'hFFFF)),
                24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 10)),
                24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 10)));
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent_base     = 0;
      while (sent_base < PHASE_ITEMS) begin
         if ($urandom_range(9) < 8) begin
            send_series();
            sent_base += 20;
         end else begin
            send_sample($urandom, 1'($urandom_range(1)));
            sent_base += 1;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0);
      run_random_phase(54, 0);
      run_random_phase(0, 54);
      run_random_phase(14, 14);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      int waited;
      lvl_one     = 0;
      lvl_two     = 0;
      lvl_three   = 0;
      series_seen = 1'b0;
      alpha_q     = ALPHA_RESET;
      trend_q     = TREND_GAIN_RESET;
      curve_q     = CURVE_GAIN_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      // Final drain, then a short window to catch stray results
      @(negedge clock);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      waited = 0;
      while (expected_forecasts.size() != 0 && waited < END_WAIT_CYC) begin
         @(posedge clock);
         waited++;
      end
      if (expected_forecasts.size() != 0)
         report_mismatch("results still outstanding", expected_forecasts.size(), 0);
      repeat (SETTLE_CYC) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
